>>> hdl/krt_pkg.sv
// shared types, constants and helpers for the keyed record table
package krt_pkg;

   localparam int CAPACITY = 64;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   localparam int KEY_W   = 32;
   localparam int GRADE_W = 9;
   localparam int TAG_W   = 32;
   localparam int OP_W    = 3;
   localparam int STAT_W  = 4;

   // grade is unsigned fixed point with six fraction bits: 1.0 .. 4.0
   localparam logic [GRADE_W-1:0] GRADE_MIN = 9'd64;
   localparam logic [GRADE_W-1:0] GRADE_MAX = 9'd256;

   // operation codes
   localparam logic [OP_W-1:0] OP_INSERT     = 3'd0;
   localparam logic [OP_W-1:0] OP_DELETE     = 3'd1;
   localparam logic [OP_W-1:0] OP_SEARCH     = 3'd2;
   localparam logic [OP_W-1:0] OP_REPLACE    = 3'd3;
   localparam logic [OP_W-1:0] OP_REPLACE_AT = 3'd4;

   // status codes
   localparam logic [STAT_W-1:0] STAT_OK        = 4'd0;
   localparam logic [STAT_W-1:0] STAT_NEG_KEY   = 4'd1;
   localparam logic [STAT_W-1:0] STAT_DUP       = 4'd2;
   localparam logic [STAT_W-1:0] STAT_BAD_GRADE = 4'd3;
   localparam logic [STAT_W-1:0] STAT_EMPTY     = 4'd4;
   localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 4'd5;
   localparam logic [STAT_W-1:0] STAT_KEY_TAKEN = 4'd6;
   localparam logic [STAT_W-1:0] STAT_BAD_POS   = 4'd7;
   localparam logic [STAT_W-1:0] STAT_FULL      = 4'd8;

   typedef struct packed {
      logic [TAG_W-1:0]   address_tag;
      logic [TAG_W-1:0]   name_tag;
      logic [GRADE_W-1:0] grade;
      logic [KEY_W-1:0]   key;
   } entry_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      entry_type         data;
   } store_wr_type;

   typedef enum logic [4:0] {
      ST_IDLE     = 5'b00001,
      ST_SCAN     = 5'b00010,
      ST_SHIFT_RD = 5'b00100,
      ST_SHIFT_WR = 5'b01000,
      ST_FINISH   = 5'b10000
   } state_type;

   function automatic logic bad_grade(input logic [GRADE_W-1:0] g);
      return (g < GRADE_MIN) || (g > GRADE_MAX);
   endfunction

   // 1-based position of a 0-based slot
   function automatic logic [CNT_W-1:0] slot_pos(input logic [ADDR_W-1:0] slot);
      return CNT_W'(slot) + CNT_W'(1);
   endfunction

endpackage

>>> hdl/krt_store.sv
// record memory: one write port, one read port with registered read data
module krt_store (
   input  logic                           clock,
   input  krt_pkg::store_wr_type          wr,
   input  logic [krt_pkg::ADDR_W-1:0]     rd_addr,
   output krt_pkg::entry_type             rd_data
);

   krt_pkg::entry_type mem [krt_pkg::CAPACITY];
   krt_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/keyed_record_table_core.sv
// keyed record table: top level with sequencer, shared key compare and result register
// a request is served by key scans over the filled slots, each stopping at a hit;
//   replace by key may scan twice, and delete then moves each later record down a slot
// response time is set by the single read port of the record memory and the one shared
//   key comparator
// one beat in flight; the next request is taken the cycle after the response is loaded
// synchronous active-high reset empties the table; memory contents are not cleared
module keyed_record_table_core (
   input  logic         clock,
   input  logic         reset,
   // request channel
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [143:0] req_tdata,   // key, new_key, position, grade, name_tag, address_tag
   input  logic [2:0]   req_tuser,   // op
   // response channel
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [119:0] rsp_tdata,   // found_position, entry_total, record_key,
                                     // record_grade, record_name_tag, record_address_tag
   output logic [3:0]   rsp_tuser    // status
);

   localparam int AW = krt_pkg::ADDR_W;
   localparam int CW = krt_pkg::CNT_W;

   // request fields
   logic [krt_pkg::OP_W-1:0]    req_op;
   logic [krt_pkg::KEY_W-1:0]   req_key;
   logic [krt_pkg::KEY_W-1:0]   req_new_key;
   logic [6:0]                  req_position;
   logic [krt_pkg::GRADE_W-1:0] req_grade;
   logic [krt_pkg::TAG_W-1:0]   req_name_tag;
   logic [krt_pkg::TAG_W-1:0]   req_address_tag;

   assign req_op          = req_tuser;
   assign req_key         = req_tdata[31:0];
   assign req_new_key     = req_tdata[63:32];
   assign req_position    = req_tdata[70:64];
   assign req_grade       = req_tdata[79:71];
   assign req_name_tag    = req_tdata[111:80];
   assign req_address_tag = req_tdata[143:112];

   // control state
   krt_pkg::state_type state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      idx_ff, idx_in;          // next slot to read in a scan
   logic               cmp_vld_ff, cmp_vld_in;  // read data holds a slot to compare
   logic               rsp_valid_ff, rsp_valid_in;

   // working payload
   logic [krt_pkg::OP_W-1:0]    op_ff, op_in;
   logic [krt_pkg::KEY_W-1:0]   key_ff, key_in;
   logic [krt_pkg::KEY_W-1:0]   new_key_ff, new_key_in;
   logic [krt_pkg::GRADE_W-1:0] grade_ff, grade_in;
   logic [krt_pkg::TAG_W-1:0]   name_ff, name_in;
   logic [krt_pkg::TAG_W-1:0]   addr_ff, addr_in;
   logic                        scan_new_ff, scan_new_in;  // scanning for new_key
   logic [AW-1:0]               cmp_idx_ff, cmp_idx_in;
   logic [AW-1:0]               slot_ff, slot_in;

   // pending result
   logic [krt_pkg::STAT_W-1:0]  res_status_ff, res_status_in;
   logic [CW-1:0]               res_pos_ff, res_pos_in;
   krt_pkg::entry_type          res_rec_ff, res_rec_in;

   // output register
   logic [krt_pkg::STAT_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [CW-1:0]               rsp_pos_ff, rsp_pos_in;
   logic [CW-1:0]               rsp_total_ff, rsp_total_in;
   krt_pkg::entry_type          rsp_rec_ff, rsp_rec_in;

   // memory port
   krt_pkg::store_wr_type wr;
   logic [AW-1:0]         rd_addr;
   krt_pkg::entry_type    rd_data;

   // scan helpers
   logic [krt_pkg::KEY_W-1:0] scan_key;
   logic                      issue;
   logic                      hit;
   logic                      miss_done;
   krt_pkg::entry_type        new_rec;

   krt_store u_store (
      .clock   (clock),
      .wr      (wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_tready = (state_ff == krt_pkg::ST_IDLE);

   // the one comparator: stored key against key or new_key
   assign scan_key  = scan_new_ff ? new_key_ff : key_ff;
   assign issue     = (idx_ff < count_ff);
   assign hit       = cmp_vld_ff && (rd_data.key == scan_key);
   assign miss_done = !issue && !cmp_vld_ff;

   // record written by a successful insert or replace
   always_comb begin
      new_rec.key         = scan_new_ff ? new_key_ff : key_ff;
      new_rec.grade       = grade_ff;
      new_rec.name_tag    = name_ff;
      new_rec.address_tag = addr_ff;
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      cmp_vld_in    = cmp_vld_ff;
      rsp_valid_in  = rsp_valid_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      new_key_in    = new_key_ff;
      grade_in      = grade_ff;
      name_in       = name_ff;
      addr_in       = addr_ff;
      scan_new_in   = scan_new_ff;
      cmp_idx_in    = cmp_idx_ff;
      slot_in       = slot_ff;
      res_status_in = res_status_ff;
      res_pos_in    = res_pos_ff;
      res_rec_in    = res_rec_ff;
      rsp_status_in = rsp_status_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_total_in  = rsp_total_ff;
      rsp_rec_in    = rsp_rec_ff;
      wr            = '0;
      rd_addr       = idx_ff[AW-1:0];

      // response beat taken
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         krt_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               op_in         = req_op;
               key_in        = req_key;
               new_key_in    = req_new_key;
               grade_in      = req_grade;
               name_in       = req_name_tag;
               addr_in       = req_address_tag;
               res_status_in = krt_pkg::STAT_OK;
               res_pos_in    = '0;
               res_rec_in    = '0;
               idx_in        = '0;
               cmp_vld_in    = 1'b0;
               scan_new_in   = 1'b0;
               state_in      = krt_pkg::ST_FINISH;
               case (req_op) inside
                  krt_pkg::OP_INSERT: begin
                     if (req_key[krt_pkg::KEY_W-1]) begin
                        res_status_in = krt_pkg::STAT_NEG_KEY;
                     end else begin
                        state_in = krt_pkg::ST_SCAN;
                     end
                  end
                  krt_pkg::OP_DELETE, krt_pkg::OP_SEARCH, krt_pkg::OP_REPLACE: begin
                     if (count_ff == '0) begin
                        res_status_in = krt_pkg::STAT_EMPTY;
                     end else if (req_key[krt_pkg::KEY_W-1]) begin
                        res_status_in = krt_pkg::STAT_NEG_KEY;
                     end else begin
                        state_in = krt_pkg::ST_SCAN;
                     end
                  end
                  krt_pkg::OP_REPLACE_AT: begin
                     if (count_ff == '0) begin
                        res_status_in = krt_pkg::STAT_EMPTY;
                     end else if (req_position == '0 || req_position > count_ff) begin
                        res_status_in = krt_pkg::STAT_BAD_POS;
                     end else if (req_new_key[krt_pkg::KEY_W-1]) begin
                        res_status_in = krt_pkg::STAT_NEG_KEY;
                     end else if (krt_pkg::bad_grade(req_grade)) begin
                        res_status_in = krt_pkg::STAT_BAD_GRADE;
                     end else begin
                        slot_in     = AW'(req_position - 7'd1);
                        scan_new_in = 1'b1;
                        state_in    = krt_pkg::ST_SCAN;
                     end
                  end
                  default: begin
                     // unknown op: ok, nothing touched
                  end
               endcase
            end
         end

         krt_pkg::ST_SCAN: begin
            // read one slot per cycle, compare it in the cycle after its read
            if (issue) begin
               idx_in = idx_ff + CW'(1);
            end
            cmp_vld_in = issue;
            cmp_idx_in = idx_ff[AW-1:0];

            if (hit) begin
               if (scan_new_ff) begin
                  res_status_in = krt_pkg::STAT_KEY_TAKEN;
                  state_in      = krt_pkg::ST_FINISH;
               end else begin
                  case (op_ff) inside
                     krt_pkg::OP_INSERT: begin
                        res_status_in = krt_pkg::STAT_DUP;
                        res_pos_in    = krt_pkg::slot_pos(cmp_idx_ff);
                        res_rec_in    = rd_data;
                        state_in      = krt_pkg::ST_FINISH;
                     end
                     krt_pkg::OP_SEARCH: begin
                        res_pos_in = krt_pkg::slot_pos(cmp_idx_ff);
                        res_rec_in = rd_data;
                        state_in   = krt_pkg::ST_FINISH;
                     end
                     krt_pkg::OP_DELETE: begin
                        res_pos_in = krt_pkg::slot_pos(cmp_idx_ff);
                        res_rec_in = rd_data;
                        slot_in    = cmp_idx_ff;
                        state_in   = krt_pkg::ST_SHIFT_RD;
                     end
                     default: begin
                        // replace by key: slot found, now check new_key
                        slot_in = cmp_idx_ff;
                        if (new_key_ff[krt_pkg::KEY_W-1]) begin
                           res_status_in = krt_pkg::STAT_NEG_KEY;
                           state_in      = krt_pkg::ST_FINISH;
                        end else if (krt_pkg::bad_grade(grade_ff)) begin
                           res_status_in = krt_pkg::STAT_BAD_GRADE;
                           state_in      = krt_pkg::ST_FINISH;
                        end else begin
                           scan_new_in = 1'b1;
                           idx_in      = '0;
                           cmp_vld_in  = 1'b0;
                        end
                     end
                  endcase
               end
            end else if (miss_done) begin
               state_in = krt_pkg::ST_FINISH;
               if (scan_new_ff) begin
                  wr.en      = 1'b1;
                  wr.addr    = slot_ff;
                  wr.data    = new_rec;
                  res_pos_in = krt_pkg::slot_pos(slot_ff);
                  res_rec_in = new_rec;
               end else if (op_ff == krt_pkg::OP_INSERT) begin
                  if (krt_pkg::bad_grade(grade_ff)) begin
                     res_status_in = krt_pkg::STAT_BAD_GRADE;
                  end else if (count_ff == CW'(krt_pkg::CAPACITY)) begin
                     res_status_in = krt_pkg::STAT_FULL;
                  end else begin
                     wr.en      = 1'b1;
                     wr.addr    = count_ff[AW-1:0];
                     wr.data    = new_rec;
                     res_pos_in = count_ff + CW'(1);
                     res_rec_in = new_rec;
                     count_in   = count_ff + CW'(1);
                  end
               end else begin
                  res_status_in = krt_pkg::STAT_NOT_FOUND;
               end
            end
         end

         krt_pkg::ST_SHIFT_RD: begin
            // close the gap: move slot + 1 down to slot
            rd_addr = AW'(krt_pkg::slot_pos(slot_ff));
            if (krt_pkg::slot_pos(slot_ff) >= count_ff) begin
               count_in = count_ff - CW'(1);
               state_in = krt_pkg::ST_FINISH;
            end else begin
               state_in = krt_pkg::ST_SHIFT_WR;
            end
         end

         krt_pkg::ST_SHIFT_WR: begin
            wr.en    = 1'b1;
            wr.addr  = slot_ff;
            wr.data  = rd_data;
            slot_in  = slot_ff + AW'(1);
            state_in = krt_pkg::ST_SHIFT_RD;
         end

         krt_pkg::ST_FINISH: begin
            // load the output register once it is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_pos_in    = res_pos_ff;
               rsp_total_in  = count_ff;
               rsp_rec_in    = res_rec_ff;
               state_in      = krt_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = krt_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= krt_pkg::ST_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      new_key_ff    <= new_key_in;
      grade_ff      <= grade_in;
      name_ff       <= name_in;
      addr_ff       <= addr_in;
      scan_new_ff   <= scan_new_in;
      cmp_idx_ff    <= cmp_idx_in;
      slot_ff       <= slot_in;
      res_status_ff <= res_status_in;
      res_pos_ff    <= res_pos_in;
      res_rec_ff    <= res_rec_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_total_ff  <= rsp_total_in;
      rsp_rec_ff    <= rsp_rec_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {1'b0,
                        rsp_rec_ff.address_tag,
                        rsp_rec_ff.name_tag,
                        rsp_rec_ff.grade,
                        rsp_rec_ff.key,
                        rsp_total_ff,
                        rsp_pos_ff};

`ifndef SYNTHESIS
   // fill count never passes capacity
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(krt_pkg::CAPACITY))
      else $error("entry count above capacity");

   // memory is written only when a scan resolves or a record moves down
   a_write_state: assert property (@(posedge clock) disable iff (reset)
      wr.en |-> (state_ff == krt_pkg::ST_SCAN || state_ff == krt_pkg::ST_SHIFT_WR))
      else $error("record memory written outside scan or shift");

   // a compared slot is always a held record
   a_cmp_slot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == krt_pkg::ST_SCAN && cmp_vld_ff) |-> (CW'(cmp_idx_ff) < count_ff))
      else $error("scan compared a slot past the fill count");

   // a response appears only out of the finish step
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == krt_pkg::ST_FINISH))
      else $error("response raised outside finish");
`endif

endmodule
